FILE: rtl/core/snoise_pkg.sv
// Package with constants and helpers shared by the 2D simplex noise pipeline.
package snoise_pkg;

  localparam logic [31:0] SkewQ32   = 32'd1572067139;
  localparam logic [31:0] UnskewQ32 = 32'd907633386;
  localparam int unsigned GradCount = 12;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_EVAL = 1'b1
  } cmd_e;

  typedef enum logic {
    REG_RANGE_MIN = 1'b0,
    REG_RANGE_MAX = 1'b1
  } reg_e;

  // Hash mod 12. The quotient comes from a reciprocal multiply by 171 / 2048,
  // which is exact for every 8-bit hash.
  function automatic logic [3:0] grad_code(input logic [7:0] h);
    logic [15:0] p;
    logic [7:0]  q;
    p = 16'(h) * 16'd171;
    q = 8'(p >> 11);
    grad_code = 4'(h - 8'(q * 8'(GradCount)));
  endfunction

  // Gradient code (hash mod 12) to x and y signs: -1, 0 or +1.
  function automatic logic signed [1:0] grad_x(input logic [7:0] h);
    logic [3:0] m;
    m = grad_code(h);
    case (m)
      4'd0, 4'd2, 4'd4, 4'd6: grad_x = 2'sd1;
      4'd1, 4'd3, 4'd5, 4'd7: grad_x = -2'sd1;
      default:                grad_x = 2'sd0;
    endcase
  endfunction

  function automatic logic signed [1:0] grad_y(input logic [7:0] h);
    logic [3:0] m;
    m = grad_code(h);
    case (m)
      4'd0, 4'd1, 4'd8, 4'd10: grad_y = 2'sd1;
      4'd2, 4'd3, 4'd9, 4'd11: grad_y = -2'sd1;
      default:                 grad_y = 2'sd0;
    endcase
  endfunction

endpackage

FILE: rtl/core/simplex_noise_2d.sv
// Top level of the pipelined 2D simplex noise evaluator.
//
// Channel  Direction  Signals                                    Beat taken when
// command  in         start_i busy_o command_i table_* coord_*   start_i && !busy_o
// result   out        noise_valid_o noise_value_o                noise_valid_o high
// config   in         cfg_we_i cfg_index_i cfg_wdata_i           cfg_we_i high
//
// Every command beat is taken as soon as it is offered; busy_o is always low, so
// one point enters per cycle. An evaluate beat travels through ten register
// stages (the skew, floor, unskew, two permutation memory reads, the squared
// radius, the two falloff squarings, the sum and the range map); its result is
// on the ports for one cycle, together with noise_valid_o.
// A load beat gives no result. It rides three register stages and then writes
// the permutation memory, so every evaluate taken before it still reads the old
// entry and every one taken after it reads the new one. Reset clears the valid
// bits and sets the range registers to 0 and 65536; the permutation memory is
// not reset. The receiver cannot stall the result side.
module simplex_noise_2d #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        command_i,
  input  logic [7:0]  table_index_i,
  input  logic [7:0]  table_value_i,
  input  logic signed [31:0] coord_x_i,
  input  logic signed [31:0] coord_y_i,
  output logic        noise_valid_o,
  output logic signed [31:0] noise_value_o,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_wdata_i
);

  localparam int F = FRAC_BITS;
  localparam int NS = 10;
  // Corner offsets stay well inside two cells, so F + 3 signed bits hold them.
  localparam int DW = F + 3;
  localparam int QW = 2 * DW;
  localparam int PW = F + 1 + DW + 2;
  localparam int SW = PW + 2;
  localparam int UW = SW + 8;
  // The mapped noise stays below sixteen in magnitude.
  localparam int WW = F + 6;
  localparam logic signed [47:0] One = 48'sd1 << F;
  // Unskew constant rounded half up to Q.F.
  localparam logic signed [47:0] GOff =
    48'((64'(snoise_pkg::UnskewQ32) + (64'd1 << (31 - F))) >> (32 - F));
  localparam logic signed [QW-1:0] Half2F = QW'(64'sd1 << (2 * F - 1));

  assign busy_o = 1'b0;

  logic accept;
  assign accept = start_i;

  // Configuration registers.
  logic signed [31:0] range_min_q, range_max_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_min_q <= '0;
      range_max_q <= 32'sd65536;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        snoise_pkg::REG_RANGE_MIN: range_min_q <= cfg_wdata_i;
        default:                   range_max_q <= cfg_wdata_i;
      endcase
    end
  end

  // Valid bits travel with the data; a load never enters the pipeline.
  logic [NS-1:0] v_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[NS-2:0], accept && (command_i == snoise_pkg::CMD_EVAL)};
    end
  end

  // Load beats are delayed so their write lands after the reads of every
  // evaluate ahead of them and before the reads of every evaluate behind them.
  logic [2:0] ld_v_q;
  logic [7:0] ld_idx_q [3], ld_val_q [3];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ld_v_q <= '0;
    end else begin
      ld_v_q <= {ld_v_q[1:0], accept && (command_i == snoise_pkg::CMD_LOAD)};
    end
  end

  always_ff @(posedge clk_i) begin
    ld_idx_q[0] <= table_index_i;
    ld_val_q[0] <= table_value_i;
    ld_idx_q[1] <= ld_idx_q[0];
    ld_val_q[1] <= ld_val_q[0];
    ld_idx_q[2] <= ld_idx_q[1];
    ld_val_q[2] <= ld_val_q[1];
  end

  // Stage 1: skew product.
  logic signed [32:0] x1_q, y1_q;
  logic signed [66:0] sp1_q;
  always_ff @(posedge clk_i) begin
    x1_q  <= 33'(coord_x_i);
    y1_q  <= 33'(coord_y_i);
    sp1_q <= 67'((34'(coord_x_i) + 34'(coord_y_i)) * $signed({1'b0, snoise_pkg::SkewQ32}));
  end

  // Stage 2: cell indexes by true floor (arithmetic shift).
  logic signed [32:0] x2_q, y2_q;
  logic signed [33:0] i2_q, j2_q;
  always_ff @(posedge clk_i) begin
    logic signed [34:0] s;
    s = 35'(sp1_q >>> 32);
    x2_q <= x1_q;
    y2_q <= y1_q;
    i2_q <= 34'((36'(x1_q) + 36'(s)) >>> F);
    j2_q <= 34'((36'(y1_q) + 36'(s)) >>> F);
  end

  // Stage 3: unskew, corner offsets and middle-corner choice.
  logic signed [DW-1:0] dx3_q [3], dy3_q [3];
  logic [7:0] ii3_q, jj3_q;
  logic i13_q;
  always_ff @(posedge clk_i) begin
    logic signed [47:0] t, x0, y0;
    logic sel;
    t  = 48'(((68'(i2_q) + 68'(j2_q)) * $signed({1'b0, snoise_pkg::UnskewQ32})) >>> (32 - F));
    x0 = 48'(x2_q) - (48'(i2_q) <<< F) + t;
    y0 = 48'(y2_q) - (48'(j2_q) <<< F) + t;
    sel = x0 > y0;
    dx3_q[0] <= DW'(x0);
    dy3_q[0] <= DW'(y0);
    dx3_q[1] <= DW'(x0 - (sel ? One : 48'sd0) + GOff);
    dy3_q[1] <= DW'(y0 - (sel ? 48'sd0 : One) + GOff);
    dx3_q[2] <= DW'(x0 - One + 2 * GOff);
    dy3_q[2] <= DW'(y0 - One + 2 * GOff);
    ii3_q <= i2_q[7:0];
    jj3_q <= j2_q[7:0];
    i13_q <= sel;
  end

  // Permutation memory, three read ports registered (one copy per port).
  logic [7:0] perm_a [256], perm_b [256], perm_c [256];
  always_ff @(posedge clk_i) begin
    if (ld_v_q[2]) begin
      perm_a[ld_idx_q[2]] <= ld_val_q[2];
      perm_b[ld_idx_q[2]] <= ld_val_q[2];
      perm_c[ld_idx_q[2]] <= ld_val_q[2];
    end
  end

  // Stage 4: first lookups on the j side.
  logic signed [DW-1:0] dx4_q [3], dy4_q [3];
  logic [7:0] ii4_q, pj4_q [3];
  logic i14_q;
  always_ff @(posedge clk_i) begin
    pj4_q[0] <= perm_a[jj3_q];
    pj4_q[1] <= perm_b[jj3_q + 8'(!i13_q)];
    pj4_q[2] <= perm_c[jj3_q + 8'd1];
    dx4_q <= dx3_q; dy4_q <= dy3_q;
    ii4_q <= ii3_q; i14_q <= i13_q;
  end

  // Stage 5: second lookups give gradient hashes.
  logic signed [DW-1:0] dx5_q [3], dy5_q [3];
  logic [7:0] h5_q [3];
  always_ff @(posedge clk_i) begin
    h5_q[0] <= perm_a[ii4_q + pj4_q[0]];
    h5_q[1] <= perm_b[ii4_q + 8'(i14_q) + pj4_q[1]];
    h5_q[2] <= perm_c[ii4_q + 8'd1 + pj4_q[2]];
    dx5_q <= dx4_q; dy5_q <= dy4_q;
  end

  // Stage 6: squared radius and gradient dot product per corner.
  logic signed [QW-1:0] q6_q [3];
  logic signed [DW+1:0] d6_q [3];
  always_ff @(posedge clk_i) begin
    logic signed [QW-1:0] sx, sy;
    logic signed [1:0] gx, gy;
    logic signed [DW:0] tx, ty;
    for (int k = 0; k < 3; k++) begin
      sx = dx5_q[k] * dx5_q[k];
      sy = dy5_q[k] * dy5_q[k];
      q6_q[k] <= Half2F - sx - sy;
      gx = snoise_pkg::grad_x(h5_q[k]);
      gy = snoise_pkg::grad_y(h5_q[k]);
      tx = (gx == 2'sd1) ? (DW + 1)'(dx5_q[k]) :
           (gx == -2'sd1) ? -(DW + 1)'(dx5_q[k]) : '0;
      ty = (gy == 2'sd1) ? (DW + 1)'(dy5_q[k]) :
           (gy == -2'sd1) ? -(DW + 1)'(dy5_q[k]) : '0;
      d6_q[k] <= tx + ty;
    end
  end

  // Stage 7: a squared; negative radius term zeroes the corner.
  logic [F-1:0] b7_q [3];
  logic signed [DW+1:0] d7_q [3];
  always_ff @(posedge clk_i) begin
    logic [F-1:0] a;
    logic [2*F-1:0] aa;
    for (int k = 0; k < 3; k++) begin
      a = q6_q[k][QW-1] ? '0 : q6_q[k][2*F-1:F];
      aa = a * a;
      b7_q[k] <= aa[2*F-1:F];
      d7_q[k] <= d6_q[k];
    end
  end

  // Stage 8: b squared gives the falloff weight.
  logic [F-1:0] c8_q [3];
  logic signed [DW+1:0] d8_q [3];
  always_ff @(posedge clk_i) begin
    logic [2*F-1:0] bb;
    for (int k = 0; k < 3; k++) begin
      bb = b7_q[k] * b7_q[k];
      c8_q[k] <= bb[2*F-1:F];
      d8_q[k] <= d7_q[k];
    end
  end

  // Stage 9: weighted sum, scaled by 70 and mapped to Q.F in [0, 1].
  logic signed [WW-1:0] w9_q;
  always_ff @(posedge clk_i) begin
    logic signed [F:0] cs;
    logic signed [PW-1:0] pr;
    logic signed [SW-1:0] sum;
    logic signed [UW-1:0] u;
    sum = '0;
    for (int k = 0; k < 3; k++) begin
      cs = signed'({1'b0, c8_q[k]});
      pr = cs * d8_q[k];
      sum = sum + SW'(pr);
    end
    u = UW'(sum) * UW'(70);
    w9_q <= WW'((u + (UW'(1) <<< (2 * F))) >>> (F + 1));
  end

  // Stage 10: range map with saturation.
  always_ff @(posedge clk_i) begin
    logic signed [32:0] span;
    logic signed [WW+32:0] prod;
    logic signed [63:0] r;
    span = 33'(range_max_q) - 33'(range_min_q);
    prod = span * w9_q;
    r = 64'(range_min_q) + 64'(prod >>> F);
    if (r > 64'sd2147483647)       noise_value_o <= 32'sh7fffffff;
    else if (r < -64'sd2147483648) noise_value_o <= 32'sh80000000;
    else                           noise_value_o <= r[31:0];
  end

  assign noise_valid_o = v_q[NS-1];

endmodule

FILE: tb/tb_simplex_noise_2d.sv
// Self-checking testbench for the 2D simplex noise evaluator.
`timescale 1ns / 1ps

module tb_simplex_noise_2d;

  // Q16.16 fixed point, matching the instance below.
  localparam int FracBits = 16;
  // Ten register stages; a few spare cycles on top before we call the block idle.
  localparam int Latency = 14;

  // Keeps the expected noise values in order and predicts each one from its
  // own copy of the permutation table and range registers.
  class noise_scoreboard;
    byte unsigned perm[256];
    longint range_lo;
    longint range_hi;
    logic signed [31:0] noise_q[$];
    int errors;
    int loads;
    int evals;

    function new();
      foreach (perm[k]) perm[k] = 0;
      range_lo = 0;
      range_hi = 65536;
      errors = 0;
      loads = 0;
      evals = 0;
    endfunction

    function void set_range(snoise_pkg::reg_e r, logic [31:0] d);
      if (r == snoise_pkg::REG_RANGE_MIN) begin
        range_lo = longint'($signed(d));
      end else begin
        range_hi = longint'($signed(d));
      end
    endfunction

    function int perm_at(longint idx);
      return int'(perm[idx & 255]);
    endfunction

    // Gradient signs for the twelve hash codes: four diagonals, then x-only
    // and y-only directions, each used twice.
    function void grad_of(int h, output longint gx, output longint gy);
      int m;
      m = h % 12;
      gx = (m < 8) ? ((m % 2 == 0) ? 1 : -1) : 0;
      case (m)
        0, 1, 8, 10: gy = 1;
        2, 3, 9, 11: gy = -1;
        default: gy = 0;
      endcase
    endfunction

    // Falloff (0.5 - r^2)^4 times the gradient dot product, in Q.2F.
    function longint corner_term(longint dx, longint dy, int h);
      longint q, a, b, c, gx, gy;
      q = (longint'(1) << (2 * FracBits - 1)) - dx * dx - dy * dy;
      if (q < 0) return 0;
      a = q >>> FracBits;
      b = (a * a) >>> FracBits;
      c = (b * b) >>> FracBits;
      grad_of(h, gx, gy);
      return c * (gx * dx + gy * dy);
    endfunction

    function void note_beat(snoise_pkg::cmd_e c, logic [7:0] idx, logic [7:0] val,
                            logic signed [31:0] px, logic signed [31:0] py);
      longint one, x, y, s, i, j, t, x0, y0, x1, y1, x2, y2, g, sum, w, res;
      longint i1, j1, ii, jj;
      int h0, h1, h2;
      if (c == snoise_pkg::CMD_LOAD) begin
        perm[idx] = val;
        loads++;
        return;
      end
      evals++;
      one = longint'(1) << FracBits;
      x = px;
      y = py;
      // Skew into the triangle grid and take a true floor for the cell.
      s = ((x + y) * longint'(1572067139)) >>> 32;
      i = (x + s) >>> FracBits;
      j = (y + s) >>> FracBits;
      t = ((i + j) * longint'(907633386)) >>> (32 - FracBits);
      x0 = x - i * one + t;
      y0 = y - j * one + t;
      // The middle corner follows the side of the diagonal the point lies on.
      if (x0 > y0) begin
        i1 = 1;
        j1 = 0;
      end else begin
        i1 = 0;
        j1 = 1;
      end
      g = (longint'(907633386) + (longint'(1) << (31 - FracBits))) >>> (32 - FracBits);
      x1 = x0 - i1 * one + g;
      y1 = y0 - j1 * one + g;
      x2 = x0 - one + 2 * g;
      y2 = y0 - one + 2 * g;
      ii = i & 255;
      jj = j & 255;
      h0 = perm_at(ii + perm_at(jj));
      h1 = perm_at(ii + i1 + perm_at(jj + j1));
      h2 = perm_at(ii + 1 + perm_at(jj + 1));
      sum = corner_term(x0, y0, h0) + corner_term(x1, y1, h1) + corner_term(x2, y2, h2);
      w = (70 * sum + (longint'(1) << (2 * FracBits))) >>> (FracBits + 1);
      res = range_lo + (((range_hi - range_lo) * w) >>> FracBits);
      if (res > 64'sd2147483647) res = 64'sd2147483647;
      if (res < -64'sd2147483648) res = -64'sd2147483648;
      noise_q.push_back(res[31:0]);
    endfunction

    function void check_result(logic signed [31:0] got);
      logic signed [31:0] want;
      if (noise_q.size() == 0) begin
        $error("noise_value: result %0d arrived with nothing expected", got);
        errors++;
        return;
      end
      want = noise_q.pop_front();
      if (got !== want) begin
        $error("noise_value: expected %0d, got %0d", want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic start_i;
  logic busy_o;
  logic command_i;
  logic [7:0] table_index_i;
  logic [7:0] table_value_i;
  logic signed [31:0] coord_x_i;
  logic signed [31:0] coord_y_i;
  logic noise_valid_o;
  logic signed [31:0] noise_value_o;
  logic cfg_we_i;
  logic cfg_index_i;
  logic [31:0] cfg_wdata_i;

  noise_scoreboard sb = new();
  int idle_pct;
  int settings_used;

  simplex_noise_2d #(.FRAC_BITS(FracBits)) u_top (
    .clk_i,
    .rst_ni,
    .start_i,
    .busy_o,
    .command_i,
    .table_index_i,
    .table_value_i,
    .coord_x_i,
    .coord_y_i,
    .noise_valid_o,
    .noise_value_o,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_wdata_i
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watch both channels at every edge. Results are checked before a new
  // beat is noted; with ten stages the two can never belong together anyway.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (noise_valid_o) sb.check_result(noise_value_o);
      if (start_i && !busy_o) begin
        sb.note_beat(snoise_pkg::cmd_e'(command_i), table_index_i, table_value_i,
                     coord_x_i, coord_y_i);
      end
    end
  end

  // Offer one command beat after a random gap and hold it until taken.
  // start_i stays high between back-to-back beats.
  task automatic send_beat(snoise_pkg::cmd_e c, logic [7:0] idx, logic [7:0] val,
                           logic signed [31:0] x, logic signed [31:0] y);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    command_i <= c;
    table_index_i <= idx;
    table_value_i <= val;
    coord_x_i <= x;
    coord_y_i <= y;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic eval_at(logic signed [31:0] x, logic signed [31:0] y);
    send_beat(snoise_pkg::CMD_EVAL, 8'($urandom), 8'($urandom), x, y);
  endtask

  // Stop sending until every expected result is back, then let the pipe empty.
  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (sb.noise_q.size() != 0) @(posedge clk_i);
    repeat (Latency) @(posedge clk_i);
  endtask

  // Both range registers are written only while the block is idle.
  task automatic set_range(logic [31:0] lo, logic [31:0] hi);
    cfg_we_i <= 1'b1;
    cfg_index_i <= snoise_pkg::REG_RANGE_MIN;
    cfg_wdata_i <= lo;
    @(posedge clk_i);
    sb.set_range(snoise_pkg::REG_RANGE_MIN, lo);
    cfg_index_i <= snoise_pkg::REG_RANGE_MAX;
    cfg_wdata_i <= hi;
    @(posedge clk_i);
    sb.set_range(snoise_pkg::REG_RANGE_MAX, hi);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    settings_used++;
  endtask

  // Coordinates: mostly near the origin where cells and the table wrap are
  // easy to reach, plus full-range values and points on integer lines.
  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $signed(32'($urandom_range(2 ** 23 - 1))) - 32'sd4194304;
      2: return 32'(($urandom_range(511) - 256) * 65536);
      default: return $signed(32'($urandom_range(2 ** 28 - 1))) - 32'sd134217728;
    endcase
  endfunction

  initial begin
    logic signed [31:0] dx[12];
    logic signed [31:0] dy[12];
    int n;
    rst_ni = 1'b0;
    start_i = 1'b0;
    command_i = snoise_pkg::CMD_LOAD;
    table_index_i = '0;
    table_value_i = '0;
    coord_x_i = '0;
    coord_y_i = '0;
    cfg_we_i = 1'b0;
    cfg_index_i = snoise_pkg::REG_RANGE_MIN;
    cfg_wdata_i = '0;
    idle_pct = 0;
    settings_used = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The whole permutation table is filled before any point is evaluated,
    // so no lookup ever touches an entry that was never written.
    for (int k = 0; k < 256; k++) begin
      send_beat(snoise_pkg::CMD_LOAD, 8'(k), 8'($urandom), '0, '0);
    end

    // Directed points: the field extremes, the origin, both sides of the cell
    // diagonal, a point right on it, and negative integers where a naive floor
    // would be off by one.
    dx = '{32'sh7fffffff, -32'sh80000000, 32'sh7fffffff, -32'sh80000000, 0, 32'sh8000,
           32'sh4000, 32'sh10000, -32'sh10000, -32'sh30000, 32'sh12345, -32'sh1};
    dy = '{32'sh7fffffff, -32'sh80000000, -32'sh80000000, 32'sh7fffffff, 0, 32'sh4000,
           32'sh8000, 32'sh10000, -32'sh20000, -32'sh30000, -32'sh6789a, 32'sh1};
    for (int k = 0; k < 12; k++) eval_at(dx[k], dy[k]);
    // A load and a corner case after the table is full: entry 255 and value 255.
    send_beat(snoise_pkg::CMD_LOAD, 8'hff, 8'hff, 32'sh7fffffff, -32'sh1);
    eval_at(32'sh00ff0000, 32'sh00ff0000);
    drain();

    // Range settings: reset default, full span, inverted full span, then a
    // random one. Phases 0 and 2 send with no idling, phases 1 and 3 idle at 88 and 31 percent.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: set_range(32'h0, 32'h10000);
        1: set_range(32'h80000000, 32'h7fffffff);
        2: set_range(32'h7fffffff, 32'h80000000);
        default: set_range($urandom, $urandom);
      endcase
      case (phase)
        0: idle_pct = 0;
        1: idle_pct = 88;
        2: idle_pct = 0;
        default: idle_pct = 31;
      endcase
      n = 0;
      while (n < 200) begin
        if ($urandom_range(9) == 0) begin
          send_beat(snoise_pkg::CMD_LOAD, 8'($urandom), 8'($urandom),
                    rand_coord(), rand_coord());
        end else begin
          eval_at(rand_coord(), rand_coord());
          n++;
        end
        // Long quiet stretch once per phase: everything comes back first.
        if (n == 100) begin
          drain();
          n++;
        end
      end
      drain();
    end

    $display("Ran %0d table loads and %0d noise evaluations over %0d range settings,",
             sb.loads, sb.evals, settings_used);
    $display("including full-span, inverted and random ranges at several idle rates.");
    if (sb.noise_q.size() != 0) begin
      $error("noise_value: %0d results never arrived", sb.noise_q.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Safety net well beyond the slowest correct run.
  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/snoise_pkg.sv
rtl/core/simplex_noise_2d.sv
tb/tb_simplex_noise_2d.sv
